// ----- hdl/elsr_pkg.sv -----
package elsr_pkg;

	localparam int NUM_EVENTS_DEF  = 48;
	localparam int TRACE_DEPTH_DEF = 4096;

	localparam int ID_W       = 6;
	localparam int IN_W       = 200;
	localparam int OUT_W      = 304;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SLOT_W     = 12;
	localparam int TRACE_W    = 198;

	localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_ONLY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END     = 3'd4;

	localparam logic [2:0] OUTC_TRACED     = 3'd0;
	localparam logic [2:0] OUTC_SUMMARIZED = 3'd1;
	localparam logic [2:0] OUTC_WINDOW     = 3'd2;
	localparam logic [2:0] OUTC_BAD_ID     = 3'd3;
	localparam logic [2:0] OUTC_NO_TRACE   = 3'd4;

	typedef struct packed {
		logic        [31:0] count;
		logic        [63:0] sum_dur;
		logic        [63:0] total_gap;
		logic signed [31:0] min_dur;
		logic signed [31:0] max_dur;
		logic signed [31:0] min_gap;
		logic signed [31:0] max_gap;
	} stat_entry_t;

	localparam int STAT_W = $bits(stat_entry_t);

	localparam stat_entry_t STAT_RESET = '{
		count:      32'd0,
		sum_dur:    64'd0,
		total_gap:  64'd0,
		min_dur:    32'sh7FFF_FFFF,
		max_dur:    32'sd0,
		min_gap:    32'sh7FFF_FFFF,
		max_gap:    32'sd0
	};

	localparam stat_entry_t STAT_ZERO = '0;

endpackage

// ----- hdl/elsr_ram.sv -----
module elsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/event_latency_stats_recorder_core.sv -----
// Event statistics and trace recorder. Each accepted word carries one timed event record;
// the block returns one result word per record with the outcome, the trace slot used and
// the event's statistics (updated if counted, zero for a bad id). The statistics memory is
// read as a word is accepted and written back as the record leaves the update stage, which
// waits while the output register holds an unaccepted result; s_tready is low while a
// record sits in that stage, so records never overlap. A finished result waits in the
// output register while the next word is taken in. Statistics entries read as their reset
// values until first written, so no clearing pass follows reset. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
module event_latency_stats_recorder_core #(
	parameter int NUM_EVENTS  = elsr_pkg::NUM_EVENTS_DEF,
	parameter int TRACE_DEPTH = elsr_pkg::TRACE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// event_id, duration, gap_time, elapsed_time, extra_one, extra_two, extra_three
	input  logic [elsr_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// outcome, trace_slot, buffer_full, count, duration sum, total_gap,
	// duration min, duration max, min_gap, max_gap
	output logic [elsr_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [elsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [elsr_pkg::CFG_DATA_W-1:0] cfg_data
);

	import elsr_pkg::*;

	localparam int SAW    = $clog2(NUM_EVENTS);
	localparam int TAW    = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
	localparam int FILL_W = $clog2(TRACE_DEPTH + 1);
	localparam logic [ID_W:0]     ID_LIMIT = (ID_W + 1)'(NUM_EVENTS);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TRACE_DEPTH);

	logic                  summary_enable_q;
	logic                  summary_only_q;
	logic                  trace_enable_q;
	logic [31:0]           window_start_q;
	logic [31:0]           window_end_q;

	logic                  in_v_s1;
	logic [TRACE_W-1:0]    data_s1;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  full_q;
	logic [NUM_EVENTS-1:0] stat_valid_q;

	logic                  accept;
	logic                  proc;
	logic [ID_W-1:0]       id_s1;
	logic signed [31:0]    t_s1;
	logic signed [31:0]    g_s1;
	logic [31:0]           el_s1;
	logic [SAW-1:0]        sidx;
	logic [STAT_W-1:0]     stat_rd;
	stat_entry_t           ent;
	stat_entry_t           upd;
	stat_entry_t           shown;
	logic                  id_ok;
	logic                  in_win;
	logic                  stat_we;
	logic                  stop;
	logic                  trace_we;
	logic                  full_set;
	logic                  full_next;
	logic [2:0]            outcome;
	logic [SLOT_W-1:0]     slot;
	logic [31:0]           fill_ext;
	logic [TRACE_W-1:0]    trace_rec;

	assign cfg_ready = 1'b1;
	assign s_tready  = !in_v_s1;
	assign accept    = s_tvalid && s_tready;
	assign proc      = in_v_s1 && (!m_valid_q || m_tready);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	assign id_s1 = data_s1[5:0];
	assign t_s1  = data_s1[37:6];
	assign g_s1  = data_s1[69:38];
	assign el_s1 = data_s1[101:70];
	assign sidx  = id_s1[SAW-1:0];

	elsr_ram #(
		.WIDTH(STAT_W),
		.DEPTH(NUM_EVENTS)
	) u_stat_ram (
		.clk    (clk),
		.wr_en  (stat_we),
		.wr_addr(sidx),
		.wr_data(upd),
		.rd_en  (accept),
		.rd_addr(s_tdata[SAW-1:0]),
		.rd_data(stat_rd)
	);

	assign trace_rec = {data_s1[197:166], data_s1[133:102], data_s1[165:134],
		data_s1[69:38], data_s1[101:70], id_s1, data_s1[37:6]};

	elsr_ram #(
		.WIDTH(TRACE_W),
		.DEPTH(TRACE_DEPTH)
	) u_trace_ram (
		.clk    (clk),
		.wr_en  (trace_we),
		.wr_addr(fill_q[TAW-1:0]),
		.wr_data(trace_rec),
		.rd_en  (1'b0),
		.rd_addr('0),
		.rd_data()
	);

	always_comb begin
		ent = stat_valid_q[sidx] ? stat_entry_t'(stat_rd) : STAT_RESET;
		upd = ent;
		if (ent.count != 32'hFFFF_FFFF) begin
			upd.count = ent.count + 32'd1;
		end
		upd.sum_dur   = ent.sum_dur + {{32{t_s1[31]}}, t_s1};
		upd.total_gap = ent.total_gap + {{32{g_s1[31]}}, g_s1};
		if (t_s1 < ent.min_dur) begin
			upd.min_dur = t_s1;
		end
		if (t_s1 > ent.max_dur) begin
			upd.max_dur = t_s1;
		end
		if (g_s1 < ent.min_gap) begin
			upd.min_gap = g_s1;
		end
		if (g_s1 > ent.max_gap) begin
			upd.max_gap = g_s1;
		end

		id_ok   = (id_s1 != '0) && ({1'b0, id_s1} < ID_LIMIT);
		in_win  = (el_s1 >= window_start_q) && (el_s1 <= window_end_q);
		stat_we = proc && id_ok && in_win && summary_enable_q;
		stop    = summary_enable_q && summary_only_q;

		trace_we = 1'b0;
		full_set = 1'b0;
		fill_ext = 32'(fill_q);
		slot     = '0;
		if (!id_ok) begin
			outcome = OUTC_BAD_ID;
			shown   = STAT_ZERO;
		end else if (!in_win) begin
			outcome = OUTC_WINDOW;
			shown   = ent;
		end else begin
			shown = summary_enable_q ? upd : ent;
			if (stop) begin
				outcome = OUTC_SUMMARIZED;
			end else if (full_q || !trace_enable_q) begin
				outcome = OUTC_NO_TRACE;
			end else if (fill_q >= FILL_MAX) begin
				outcome  = OUTC_NO_TRACE;
				full_set = proc;
			end else begin
				outcome  = OUTC_TRACED;
				trace_we = proc;
				slot     = fill_ext[SLOT_W-1:0];
			end
		end
		full_next = full_q || full_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_enable_q <= 1'b1;
			summary_only_q   <= 1'b0;
			trace_enable_q   <= 1'b0;
			window_start_q   <= '0;
			window_end_q     <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SUMMARY_ENABLE: summary_enable_q <= cfg_data[0];
				REG_SUMMARY_ONLY:   summary_only_q   <= cfg_data[0];
				REG_TRACE_ENABLE:   trace_enable_q   <= cfg_data[0];
				REG_WINDOW_START:   window_start_q   <= cfg_data;
				REG_WINDOW_END:     window_end_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1      <= 1'b0;
			m_valid_q    <= 1'b0;
			fill_q       <= '0;
			full_q       <= 1'b0;
			stat_valid_q <= '0;
		end else begin
			if (accept) begin
				in_v_s1 <= 1'b1;
			end else if (proc) begin
				in_v_s1 <= 1'b0;
			end
			if (proc) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (trace_we) begin
				fill_q <= fill_q + 1'b1;
			end
			full_q <= full_next;
			if (stat_we) begin
				stat_valid_q[sidx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata[TRACE_W-1:0];
		end
		if (proc) begin
			m_data_q <= {shown.max_gap, shown.min_gap, shown.max_dur, shown.min_dur,
				shown.total_gap, shown.sum_dur, shown.count, full_next, slot, outcome};
		end
	end

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(full_q))
		else $error("buffer full flag cleared");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("trace fill level beyond depth");

	a_full_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> fill_q == FILL_MAX)
		else $error("buffer full flag set with free slots");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		trace_we |=> fill_q == FILL_W'($past(fill_q) + 1'b1))
		else $error("trace fill level did not advance after append");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		stat_we |-> !accept)
		else $error("statistics read issued during write back");

endmodule
